@@ design/fcc_pkg.sv @@
// Package: shared widths, codes and pipeline stage types of the frustum cull classifier.
`default_nettype none
package fcc_pkg;

   localparam int COORD_BITS = 16;
   localparam int PLANES     = 6;
   localparam int AXES       = 3;
   localparam int VERTS      = 3;
   localparam int NORM_W     = 16;
   localparam int RADIUS_W   = 15;
   localparam int CMD_W      = 2;
   localparam int VERDICT_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Q1.14 normal times Q8.8 vertex; scaled vertices add 8 more fraction bits
   localparam int OFF_SHIFT    = 14;
   localparam int SOFF_SHIFT   = 22;
   localparam int RAD_SHIFT    = 14;

   localparam int PROD_W  = COORD_BITS + NORM_W;
   localparam int HV_W    = 2 * COORD_BITS;
   localparam int NS_W    = HV_W + NORM_W;
   localparam int DIST_W  = ((PROD_W > NORM_W + OFF_SHIFT) ? PROD_W : NORM_W + OFF_SHIFT) + 3;
   localparam int SDIST_W = ((NS_W > NORM_W + SOFF_SHIFT) ? NS_W : NORM_W + SOFF_SHIFT) + 3;

   localparam logic [CMD_W-1:0] CMD_POINT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPHERE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TRIANGLE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_VOLUME   = 2'd3;

   localparam logic [VERDICT_W-1:0] VERDICT_CONTAINS  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [NORM_W-1:0]     norm_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [HV_W-1:0]       hv_type;
   typedef logic signed [NS_W-1:0]       ns_type;

   typedef struct packed {
      logic [NORM_W-1:0] off;
      logic [NORM_W-1:0] nz;
      logic [NORM_W-1:0] ny;
      logic [NORM_W-1:0] nx;
   } plane_type;

   typedef plane_type [PLANES-1:0] plane_set_type;

   typedef struct packed {
      logic [CMD_W-1:0]                          cmd;
      logic [RADIUS_W-1:0]                       radius;
      prod_type [PLANES-1:0][VERTS-1:0][AXES-1:0] nv;
      hv_type [VERTS-1:0][AXES-1:0]              hv;
   } s1_type;

   typedef struct packed {
      logic [CMD_W-1:0]                         cmd;
      logic [PLANES-1:0][VERTS-1:0]             behind;
      logic [PLANES-1:0]                        sph_out;
      ns_type [PLANES-1:0][VERTS-1:0][AXES-1:0] ns;
   } s2_type;

   typedef struct packed {
      logic [CMD_W-1:0]             cmd;
      logic [PLANES-1:0][VERTS-1:0] behind;
      logic [PLANES-1:0]            sph_out;
      logic [PLANES-1:0][VERTS-1:0] sbehind;
   } s3_type;

   function automatic norm_type plane_norm(plane_type pl, logic [1:0] axis);
      norm_type n;
      case (axis)
         AXIS_X:  n = $signed(pl.nx);
         AXIS_Y:  n = $signed(pl.ny);
         AXIS_Z:  n = $signed(pl.nz);
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

@@ design/fcc_ifs.sv @@
// Interfaces: request, response and register write channels.
`default_nettype none
interface fcc_req_if import fcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   coord_type           ax;
   coord_type           ay;
   coord_type           az;
   coord_type           bx;
   coord_type           by;
   coord_type           bz;
   coord_type           cx;
   coord_type           cy;
   coord_type           cz;
   logic [RADIUS_W-1:0] radius;
   coord_type           height;

   modport source (output valid, cmd, ax, ay, az, bx, by, bz, cx, cy, cz, radius, height,
                   input ready);
   modport sink   (input valid, cmd, ax, ay, az, bx, by, bz, cx, cy, cz, radius, height,
                   output ready);
endinterface

interface fcc_rsp_if import fcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;

   modport source (output valid, verdict, input ready);
   modport sink   (input valid, verdict, output ready);
endinterface

interface fcc_csr_if import fcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/fcc_prod_stage.sv @@
// Stage 1: normal-by-vertex and vertex-by-height products.
`default_nettype none
module fcc_prod_stage import fcc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   fcc_req_if.sink            req_bus,
   input  wire plane_set_type planes,
   output logic               out_valid,
   input  wire logic          out_ready,
   output s1_type             out_data
);

   logic      valid_ff;
   s1_type    s1_ff;
   s1_type    s1_in;
   coord_type vtx [VERTS][AXES];

   always_comb begin
      vtx[0][0] = req_bus.ax;
      vtx[0][1] = req_bus.ay;
      vtx[0][2] = req_bus.az;
      vtx[1][0] = req_bus.bx;
      vtx[1][1] = req_bus.by;
      vtx[1][2] = req_bus.bz;
      vtx[2][0] = req_bus.cx;
      vtx[2][1] = req_bus.cy;
      vtx[2][2] = req_bus.cz;
   end

   always_comb begin
      s1_in.cmd    = req_bus.cmd;
      s1_in.radius = req_bus.radius;
      for (int k = 0; k < VERTS; k++) begin
         for (int j = 0; j < AXES; j++) begin
            s1_in.hv[k][j] = $signed(vtx[k][j]) * $signed(req_bus.height);
         end
      end
      for (int p = 0; p < PLANES; p++) begin
         for (int k = 0; k < VERTS; k++) begin
            for (int j = 0; j < AXES; j++) begin
               s1_in.nv[p][k][j] = plane_norm(planes[p], 2'(j)) * $signed(vtx[k][j]);
            end
         end
      end
   end

   assign req_bus.ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_ff <= s1_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = s1_ff;

endmodule
`default_nettype wire

@@ design/fcc_dist_stage.sv @@
// Stage 2: vertex and sphere distance signs, normal-by-scaled-vertex products.
`default_nettype none
module fcc_dist_stage import fcc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire plane_set_type planes,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire s1_type        in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output s2_type             out_data
);

   logic   valid_ff;
   s2_type s2_ff;
   s2_type s2_in;

   always_comb begin
      logic signed [DIST_W-1:0] bias;
      logic signed [DIST_W-1:0] rad;
      logic signed [DIST_W-1:0] dsum;
      s2_in.cmd = in_data.cmd;
      rad = $signed(DIST_W'(in_data.radius)) <<< RAD_SHIFT;
      for (int p = 0; p < PLANES; p++) begin
         bias = DIST_W'($signed(planes[p].off)) <<< OFF_SHIFT;
         for (int k = 0; k < VERTS; k++) begin
            dsum = DIST_W'(in_data.nv[p][k][0]) + DIST_W'(in_data.nv[p][k][1])
                 + DIST_W'(in_data.nv[p][k][2]) - bias;
            s2_in.behind[p][k] = dsum[DIST_W-1];
            for (int j = 0; j < AXES; j++) begin
               s2_in.ns[p][k][j] = plane_norm(planes[p], 2'(j)) * in_data.hv[k][j];
            end
         end
         dsum = DIST_W'(in_data.nv[p][0][0]) + DIST_W'(in_data.nv[p][0][1])
              + DIST_W'(in_data.nv[p][0][2]) - bias + rad;
         s2_in.sph_out[p] = dsum[DIST_W-1];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = s2_ff;

endmodule
`default_nettype wire

@@ design/fcc_scaled_stage.sv @@
// Stage 3: distance signs of height-scaled vertices.
`default_nettype none
module fcc_scaled_stage import fcc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire plane_set_type planes,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire s2_type        in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output s3_type             out_data
);

   logic   valid_ff;
   s3_type s3_ff;
   s3_type s3_in;

   always_comb begin
      logic signed [SDIST_W-1:0] bias;
      logic signed [SDIST_W-1:0] dsum;
      s3_in.cmd     = in_data.cmd;
      s3_in.behind  = in_data.behind;
      s3_in.sph_out = in_data.sph_out;
      for (int p = 0; p < PLANES; p++) begin
         bias = SDIST_W'($signed(planes[p].off)) <<< SOFF_SHIFT;
         for (int k = 0; k < VERTS; k++) begin
            dsum = SDIST_W'(in_data.ns[p][k][0]) + SDIST_W'(in_data.ns[p][k][1])
                 + SDIST_W'(in_data.ns[p][k][2]) - bias;
            s3_in.sbehind[p][k] = dsum[SDIST_W-1];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = s3_ff;

endmodule
`default_nettype wire

@@ design/fcc_verdict_stage.sv @@
// Stage 4: per-plane flags reduced to the verdict, held in the output register.
`default_nettype none
module fcc_verdict_stage import fcc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire s3_type in_data,
   fcc_rsp_if.source   rsp_bus
);

   logic                 valid_ff;
   logic [VERDICT_W-1:0] verdict_ff;
   logic [VERDICT_W-1:0] verdict_in;

   always_comb begin
      logic any_a;
      logic any_vtx;
      logic any_sph;
      logic any_all;
      logic any_vol;
      any_a   = 1'b0;
      any_vtx = 1'b0;
      any_sph = 1'b0;
      any_all = 1'b0;
      any_vol = 1'b0;
      for (int p = 0; p < PLANES; p++) begin
         any_a   = any_a | in_data.behind[p][0];
         any_vtx = any_vtx | (|in_data.behind[p]);
         any_sph = any_sph | in_data.sph_out[p];
         any_all = any_all | (&in_data.behind[p]);
         any_vol = any_vol | ((&in_data.behind[p]) & (&in_data.sbehind[p]));
      end
      case (in_data.cmd)
         CMD_POINT: begin
            verdict_in = any_a ? VERDICT_OUTSIDE : VERDICT_CONTAINS;
         end
         CMD_SPHERE: begin
            verdict_in = any_sph ? VERDICT_OUTSIDE :
                         any_a   ? VERDICT_INTERSECT : VERDICT_CONTAINS;
         end
         CMD_TRIANGLE: begin
            verdict_in = any_all ? VERDICT_OUTSIDE :
                         any_vtx ? VERDICT_INTERSECT : VERDICT_CONTAINS;
         end
         CMD_VOLUME: begin
            verdict_in = any_vol ? VERDICT_OUTSIDE :
                         any_vtx ? VERDICT_INTERSECT : VERDICT_CONTAINS;
         end
         default: begin
            verdict_in = VERDICT_CONTAINS;
         end
      endcase
   end

   assign in_ready = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_bus.valid   = valid_ff;
   assign rsp_bus.verdict = verdict_ff;

endmodule
`default_nettype wire

@@ design/frustum_cull_classifier_top.sv @@
// A request beat passes the product, distance, scaled and verdict registers to its response beat on rsp_bus.
// Throughput: one primitive per cycle while rsp_bus is ready; the four-stage product/sum pipeline sets it.
// Backpressure stalls each stage in place; a full stage still drains into a free one.
// Reset clears all stage valid bits and all six plane registers to zero.
// Register writes are always accepted; indices above five are dropped.
`default_nettype none
module frustum_cull_classifier_top import fcc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   fcc_req_if.sink   req_bus,
   fcc_rsp_if.source rsp_bus,
   fcc_csr_if.sink   csr_bus
);

   plane_set_type planes_ff;
   logic          s1_valid;
   logic          s1_ready;
   s1_type        s1_data;
   logic          s2_valid;
   logic          s2_ready;
   s2_type        s2_data;
   logic          s3_valid;
   logic          s3_ready;
   s3_type        s3_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else if (csr_bus.valid && (csr_bus.index < CSR_IDX_W'(PLANES))) begin
         planes_ff[csr_bus.index] <= plane_type'(csr_bus.data);
      end
   end

   fcc_prod_stage u_prod (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .planes    (planes_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   fcc_dist_stage u_dist (
      .clock     (clock),
      .reset     (reset),
      .planes    (planes_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   fcc_scaled_stage u_scaled (
      .clock     (clock),
      .reset     (reset),
      .planes    (planes_ff),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   fcc_verdict_stage u_verdict (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_valid),
      .in_ready (s3_ready),
      .in_data  (s3_data),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

@@ test/tb_frustum_cull_classifier_top.sv @@
// Testbench: random and directed six-plane culling checks of frustum_cull_classifier_top.
`timescale 1ns / 1ps
module tb_frustum_cull_classifier_top;
   import fcc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 10;
   localparam int Q88_ONE     = 256;
   localparam int Q114_ONE    = 16384;

   localparam logic [CSR_IDX_W-1:0] IDX_NEAR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_FAR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_LEFT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_RIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] IDX_TOP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] IDX_BOTTOM = 3'd5;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE0 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE1 = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]                             cmd;
      logic [VERTS-1:0][AXES-1:0][COORD_BITS-1:0]   vtx;
      logic [RADIUS_W-1:0]                          radius;
      logic [COORD_BITS-1:0]                        height;
   } prim_type;

   logic clock;
   logic reset;

   fcc_req_if req_bus();
   fcc_rsp_if rsp_bus();
   fcc_csr_if csr_bus();

   frustum_cull_classifier_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [1:0] axis_of [PLANES] = '{AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y, AXIS_Y};
   int         sign_of [PLANES] = '{1, -1, 1, -1, -1, 1};

   plane_set_type              plane_regs;
   prim_type                   pending_prims[$];
   logic [VERDICT_W-1:0]       expected_verdicts[$];
   prim_type                   beat_out;
   int                         error_count;
   int                         cycle_count;
   int                         burst_left;
   int                         gap_left;
   bit                         send_now;
   int                         stall_mode;
   int                         mode_left;
   int                         stall_left;
   int                         tick;
   bit                         ready_next;
   logic [VERDICT_W-1:0]       exp_verdict;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic int rand_span(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [15:0] clip16(int v);
      if (v > 32767)
         return 16'h7FFF;
      if (v < -32768)
         return 16'h8000;
      return 16'(v);
   endfunction

   function automatic int rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)
         return int'($signed(16'($urandom)));
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
         endcase
      end
      return rand_span(127 * Q88_ONE);
   endfunction

   // exact fixed-point distances, planes in order until one rejects
   function automatic logic [VERDICT_W-1:0] classify(prim_type pr);
      longint nrm[AXES];
      longint pos[VERTS][AXES];
      longint vdist[VERTS];
      longint sdist[VERTS];
      longint off_q, rad, h;
      int nbehind, sbehind, p, k;
      logic [VERDICT_W-1:0] verdict;
      bit done;
      verdict = VERDICT_CONTAINS;
      done = 1'b0;
      rad = longint'(pr.radius);
      h = sx16(pr.height);
      for (k = 0; k < VERTS; k++) begin
         pos[k][0] = sx16(pr.vtx[k][0]);
         pos[k][1] = sx16(pr.vtx[k][1]);
         pos[k][2] = sx16(pr.vtx[k][2]);
      end
      for (p = 0; p < PLANES && !done; p++) begin
         nrm[0] = sx16(plane_regs[p].nx);
         nrm[1] = sx16(plane_regs[p].ny);
         nrm[2] = sx16(plane_regs[p].nz);
         off_q = sx16(plane_regs[p].off);
         nbehind = 0;
         sbehind = 0;
         for (k = 0; k < VERTS; k++) begin
            vdist[k] = nrm[0] * pos[k][0] + nrm[1] * pos[k][1] + nrm[2] * pos[k][2]
                       - off_q * 16384;
            sdist[k] = nrm[0] * (pos[k][0] * h) + nrm[1] * (pos[k][1] * h)
                       + nrm[2] * (pos[k][2] * h) - off_q * 4194304;
            if (vdist[k] < 0)
               nbehind++;
            if (sdist[k] < 0)
               sbehind++;
         end
         case (pr.cmd)
            CMD_POINT: begin
               if (vdist[0] < 0) begin
                  verdict = VERDICT_OUTSIDE;
                  done = 1'b1;
               end
            end
            CMD_SPHERE: begin
               if (vdist[0] + rad * 16384 < 0) begin
                  verdict = VERDICT_OUTSIDE;
                  done = 1'b1;
               end else if (vdist[0] < 0) begin
                  verdict = VERDICT_INTERSECT;
               end
            end
            default: begin
               if (nbehind == VERTS) begin
                  if (pr.cmd == CMD_TRIANGLE || sbehind == VERTS) begin
                     verdict = VERDICT_OUTSIDE;
                     done = 1'b1;
                  end else begin
                     verdict = VERDICT_INTERSECT;
                  end
               end else if (nbehind > 0) begin
                  verdict = VERDICT_INTERSECT;
               end
            end
         endcase
      end
      return verdict;
   endfunction

   function automatic prim_type prim(logic [CMD_W-1:0] cmd, int ax, int ay, int az,
                                     int bx, int by, int bz, int cx, int cy, int cz,
                                     int rad, int h);
      prim_type pr;
      pr.cmd = cmd;
      pr.vtx[0][0] = clip16(ax);
      pr.vtx[0][1] = clip16(ay);
      pr.vtx[0][2] = clip16(az);
      pr.vtx[1][0] = clip16(bx);
      pr.vtx[1][1] = clip16(by);
      pr.vtx[1][2] = clip16(bz);
      pr.vtx[2][0] = clip16(cx);
      pr.vtx[2][1] = clip16(cy);
      pr.vtx[2][2] = clip16(cz);
      pr.radius = RADIUS_W'(rad);
      pr.height = clip16(h);
      return pr;
   endfunction

   function automatic prim_type rand_prim();
      prim_type pr;
      int ctr[AXES];
      int spread, r, k, j;
      pr.cmd = CMD_W'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      spread = (r < 5) ? 4 * Q88_ONE : (r < 8) ? 32 * Q88_ONE : 65535;
      for (j = 0; j < AXES; j++)
         ctr[j] = rand_coord();
      for (k = 0; k < VERTS; k++)
         for (j = 0; j < AXES; j++)
            pr.vtx[k][j] = (k == 0) ? clip16(ctr[j]) : clip16(ctr[j] + rand_span(spread));
      if ($urandom_range(0, 9) == 0)
         pr.radius = RADIUS_W'($urandom);
      else
         pr.radius = RADIUS_W'($urandom_range(0, 48 * Q88_ONE));
      case ($urandom_range(0, 7))
         0: pr.height = 16'(Q88_ONE);
         1: pr.height = 16'(-Q88_ONE);
         2: pr.height = 16'h0000;
         3: pr.height = ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
         4, 5: pr.height = 16'($urandom);
         default: pr.height = 16'(rand_span(4 * Q88_ONE));
      endcase
      return pr;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] axis_plane(int p, int half, int tilt);
      logic [15:0] n[AXES];
      int j;
      for (j = 0; j < AXES; j++)
         n[j] = 16'(rand_span(tilt));
      n[axis_of[p]] = 16'(sign_of[p] * Q114_ONE + rand_span(tilt));
      return {16'(-half), n[2], n[1], n[0]};
   endfunction

   task automatic add_prim(input prim_type pr);
      pending_prims = {pending_prims, pr};
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      if (idx < PLANES)
         plane_regs[idx] = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_box(input int half_lo, input int half_hi, input int tilt);
      int p;
      for (p = 0; p < PLANES; p++)
         csr_write(CSR_IDX_W'(p), axis_plane(p, $urandom_range(half_lo, half_hi), tilt));
   endtask

   task automatic wait_idle();
      while (pending_prims.size() != 0 || req_bus.valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // request driver: bursts of beats with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            expected_verdicts = {expected_verdicts, classify(beat_out)};
         if (!req_bus.valid || req_bus.ready) begin
            send_now = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end
            if (burst_left > 0) begin
               if (pending_prims.size() > 0) begin
                  beat_out = pending_prims.pop_front();
                  send_now = 1'b1;
                  burst_left--;
               end
            end else begin
               gap_left--;
            end
            req_bus.valid <= send_now;
            if (send_now) begin
               req_bus.cmd    <= beat_out.cmd;
               req_bus.ax     <= beat_out.vtx[0][0];
               req_bus.ay     <= beat_out.vtx[0][1];
               req_bus.az     <= beat_out.vtx[0][2];
               req_bus.bx     <= beat_out.vtx[1][0];
               req_bus.by     <= beat_out.vtx[1][1];
               req_bus.bz     <= beat_out.vtx[1][2];
               req_bus.cx     <= beat_out.vtx[2][0];
               req_bus.cy     <= beat_out.vtx[2][1];
               req_bus.cz     <= beat_out.vtx[2][2];
               req_bus.radius <= beat_out.radius;
               req_bus.height <= beat_out.height;
            end
         end
      end
   end

   // response monitor and ready pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: unexpected verdict beat, expected none, actual %0d",
                        $time, rsp_bus.verdict);
            end else begin
               exp_verdict = expected_verdicts.pop_front();
               if (rsp_bus.verdict !== exp_verdict) begin
                  error_count++;
                  $display("%0t: verdict mismatch, expected %0d, actual %0d",
                           $time, exp_verdict, rsp_bus.verdict);
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         tick++;
         case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = $urandom_range(0, 1);
            2: ready_next = (tick % 4 == 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  ready_next = 1'b0;
               end else begin
                  ready_next = 1'b1;
                  if ($urandom_range(0, 3) == 0)
                     stall_left = $urandom_range(1, 16);
               end
            end
         endcase
         rsp_bus.ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = 0;
      mode_left = 0;
      stall_left = 0;
      tick = 0;
      plane_regs = '0;
      beat_out = '0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_POINT;
      req_bus.ax = '0;
      req_bus.ay = '0;
      req_bus.az = '0;
      req_bus.bx = '0;
      req_bus.by = '0;
      req_bus.bz = '0;
      req_bus.cx = '0;
      req_bus.cy = '0;
      req_bus.cz = '0;
      req_bus.radius = '0;
      req_bus.height = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = IDX_NEAR;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // planes still zero after reset: nothing rejects
      repeat (30) add_prim(rand_prim());
      wait_idle();

      // axis box of half size 64
      write_box(64 * Q88_ONE, 64 * Q88_ONE, 0);
      add_prim(prim(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_prim(prim(CMD_POINT, -16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_prim(prim(CMD_POINT, -16385, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_prim(prim(CMD_POINT, 32767, 32767, 32767,
                    -32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768));
      add_prim(prim(CMD_POINT, -32768, -32768, -32768,
                    32767, 32767, 32767, -32768, -32768, -32768, 0, 32767));
      add_prim(prim(CMD_SPHERE, -20480, 0, 0, 0, 0, 0, 0, 0, 0, 4096, 0));
      add_prim(prim(CMD_SPHERE, -20480, 0, 0, 0, 0, 0, 0, 0, 0, 4095, 0));
      add_prim(prim(CMD_SPHERE, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 0));
      add_prim(prim(CMD_SPHERE, 0, 0, 0, -32768, 0, 0, 0, 0, 0, 0, -32768));
      add_prim(prim(CMD_SPHERE, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0));
      add_prim(prim(CMD_TRIANGLE, 0, 0, 0, 256, 256, 256, -256, 0, 512,
                    32767, 32767));
      add_prim(prim(CMD_TRIANGLE, -20000, 0, 0, 256, 256, 256, 0, 0, 0, 0, 0));
      add_prim(prim(CMD_TRIANGLE, -20000, 0, 0, -25000, 100, 0,
                    -30000, -100, 0, 0, 0));
      add_prim(prim(CMD_TRIANGLE, -20000, 0, 0, 20000, 0, 0,
                    0, 20000, 0, 0, 0));
      add_prim(prim(CMD_TRIANGLE, -16384, 0, 0, -16384, 100, 0,
                    -16384, 0, 100, 0, 0));
      add_prim(prim(CMD_TRIANGLE, 32767, 32767, 32767, -32768, -32768, -32768,
                    32767, -32768, 0, 0, 0));
      add_prim(prim(CMD_VOLUME, -20000, 0, 0, -25000, 100, 0,
                    -30000, -100, 0, 0, 256));
      add_prim(prim(CMD_VOLUME, -20000, 0, 0, -25000, 100, 0,
                    -30000, -100, 0, 0, -256));
      add_prim(prim(CMD_VOLUME, -20000, 0, 0, -25000, 100, 0,
                    -30000, -100, 0, 0, 0));
      add_prim(prim(CMD_VOLUME, -20000, 0, 0, -25000, 100, 0,
                    -30000, -100, 0, 0, 32767));
      add_prim(prim(CMD_VOLUME, -20000, 0, 0, -25000, 100, 0,
                    -30000, -100, 0, 0, -32768));
      add_prim(prim(CMD_VOLUME, 0, 0, 0, 256, 256, 256, -256, 0, 512,
                    32767, -32768));
      add_prim(prim(CMD_VOLUME, -20000, 0, 0, 0, 0, 0, 100, 100, 100, 0, 256));
      add_prim(prim(CMD_VOLUME, -32768, -32768, -32768, -32768, -32768, -32768,
                    -32768, -32768, -32768, 0, 32767));
      repeat (250) add_prim(rand_prim());
      wait_idle();

      // tilted box; sender holds off mid-phase until all verdicts are back
      write_box(8 * Q88_ONE, 117 * Q88_ONE, 3000);
      repeat (200) add_prim(rand_prim());
      wait_idle();
      repeat (200) add_prim(rand_prim());
      wait_idle();

      // writes past the last plane are dropped
      csr_write(IDX_SPARE0, {$urandom, $urandom});
      csr_write(IDX_SPARE1, {CSR_DATA_W{1'b1}});
      write_box(16 * Q88_ONE, 96 * Q88_ONE, 1500);
      repeat (350) add_prim(rand_prim());
      wait_idle();

      // extreme register values
      csr_write(IDX_NEAR,   {16'h8000, 16'h7FFF, 16'h0000, 16'h0000});
      csr_write(IDX_FAR,    {16'h7FFF, 16'h8000, 16'h0000, 16'h0000});
      csr_write(IDX_LEFT,   {16'h8000, 16'h0000, 16'h0000, 16'h7FFF});
      csr_write(IDX_RIGHT,  {CSR_DATA_W{1'b1}});
      csr_write(IDX_TOP,    64'h8000_8000_8000_8000);
      csr_write(IDX_BOTTOM, 64'h7FFF_7FFF_7FFF_7FFF);
      repeat (250) add_prim(rand_prim());
      wait_idle();

      // arbitrary register contents
      csr_write(IDX_NEAR,   {$urandom, $urandom});
      csr_write(IDX_FAR,    {$urandom, $urandom});
      csr_write(IDX_LEFT,   {$urandom, $urandom});
      csr_write(IDX_RIGHT,  {$urandom, $urandom});
      csr_write(IDX_TOP,    {$urandom, $urandom});
      csr_write(IDX_BOTTOM, {$urandom, $urandom});
      repeat (250) add_prim(rand_prim());
      wait_idle();

      // small box, bottom plane zeroed
      write_box(Q88_ONE, 16 * Q88_ONE, 500);
      csr_write(IDX_BOTTOM, '0);
      repeat (320) add_prim(rand_prim());
      wait_idle();

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
